/* sv/pfp_pkg.sv */
// Shared constants, types and tables of the propagation filter.
package pfp_pkg;

  // Sizing of the window, the line store and the weight table.
  localparam int MAX_RADIUS      = 7;
  localparam int MAX_WIDTH       = 1024;
  localparam int CHANNELS        = 3;
  localparam int EXP_TABLE_DEPTH = 1024;

  localparam int WIN_SIDE = 2 * MAX_RADIUS + 1;
  localparam int WIN_N    = WIN_SIDE * WIN_SIDE;
  localparam int WIN_AW   = $clog2(WIN_N);
  localparam int LS_DEPTH = WIN_SIDE * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int EXP_AW   = $clog2(EXP_TABLE_DEPTH);

  // Ring counter holds one past the largest radius; offsets carry a sign bit.
  localparam int RAD_W = $clog2(MAX_RADIUS + 2);
  localparam int OFF_W = RAD_W + 1;

  // Field widths fixed by the interface.
  localparam int PIX_W    = 24;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 10;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int LIN_W    = ROW_W + WIDTH_W;
  localparam int CNT_W    = 24;

  // Arithmetic widths.
  localparam int D2_W     = 18;
  localparam int LOGW_W   = 22;
  localparam int NEG_W    = 28;
  localparam int WT_W     = 17;
  localparam int ONE_Q16  = 65536;
  localparam int TOTAL_W  = $clog2(ONE_Q16 * WIN_N + 1);
  localparam int SUM_W    = TOTAL_W + 8;
  localparam int DIV_W    = SUM_W + 2;
  localparam int QUO_W    = 9;
  localparam logic [LOGW_W-1:0] LOGW_MAX = {LOGW_W{1'b1}};

  // Reciprocal for the store address modulo: one correction step suffices.
  localparam int MOD_SHIFT = 32;
  localparam longint unsigned LS_RECIP = (64'd1 << MOD_SHIFT) / LS_DEPTH;

  // Exp table step, exp(-1/64) in Q0.32.
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380000;

  // Request kinds and configuration register indexes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_RADIUS        = 3'd2,
    CFG_SPATIAL_SCALE = 3'd3,
    CFG_RANGE_SCALE   = 3'd4,
    CFG_COLOR_MODE    = 3'd5
  } cfg_reg_t;

  typedef logic [WT_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  // Builds the weight table, exp(-i/64) in Q.16, by repeated multiplication.
  function automatic exp_rom_t exp_rom_build();
    exp_rom_t    rom;
    logic [63:0] v;
    v = 64'd1 << 32;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      rom[i] = WT_W'((v + 64'h8000) >> 16);
      v = (v * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = exp_rom_build();

  // One 8-bit channel of a packed pixel.
  function automatic logic [7:0] chan_of(logic [PIX_W-1:0] px, logic [1:0] z);
    return px[8*z +: 8];
  endfunction

  // Linear index of a window offset in the log weight store.
  function automatic logic [WIN_AW-1:0] win_idx(logic signed [OFF_W-1:0] v,
                                                logic signed [OFF_W-1:0] h);
    return WIN_AW'((int'(v) + MAX_RADIUS) * WIN_SIDE + int'(h) + MAX_RADIUS);
  endfunction

endpackage

/* sv/propagation_filter_pixel.sv */
// Propagation filter top level: line store, ring walk sequencer and shared datapath.
// A request that releases an output walks the in-image window targets (up to 2R(R+1));
// targets that fall outside the image are skipped, and an output stall holds it. Every
// pixel read goes through the shared store address unit, and the single multiplier
// is used twice per distance.
// Reset is synchronous: counters, sequencer, output valid and registers go to defaults.
module propagation_filter_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // chan_a, chan_b, chan_c
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // res_a, res_b, res_c, out_row, out_col, zero pad
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_WADR, S_WRITE, S_CHK1, S_CHK2, S_CADR, S_CCAP, S_TSEL, S_TADR,
    S_TCAP, S_PADR, S_PCAP, S_DIST, S_MLO, S_MHI, S_MADD, S_WT, S_ACC,
    S_DIVI, S_DIV, S_OUT
  } state_t;

  localparam logic [1:0] AU_WAIT = 2'd3;

  // Configuration registers.
  logic [pfp_pkg::WIDTH_W-1:0]  image_width;
  logic [pfp_pkg::HEIGHT_W-1:0] image_height;
  logic [2:0]                   radius;
  logic [31:0]                  spatial_scale;
  logic [31:0]                  range_scale;
  logic                         color_mode;

  // Frame counters.
  logic [pfp_pkg::ROW_W-1:0] in_row, emit_row;
  logic [pfp_pkg::COL_W-1:0] in_col, emit_col;

  // Sequencer and datapath registers.
  state_t                          state;
  logic [1:0]                      wcnt;
  logic [pfp_pkg::PIX_W-1:0]       px, cpx, tpx, ppx;
  logic [pfp_pkg::CNT_W-1:0]       rcv, base;
  logic [pfp_pkg::RAD_W-1:0]       r, dp;
  logic                            psn, qsn, sel;
  logic [pfp_pkg::NEG_W-1:0]       neg;
  logic [pfp_pkg::D2_W-1:0]        d2;
  logic [33:0]                     mlo, mhi;
  logic [pfp_pkg::WT_W-1:0]        wt;
  logic [1:0]                      ch;
  logic [pfp_pkg::SUM_W-1:0]       sums [3];
  logic [pfp_pkg::TOTAL_W-1:0]     total;
  logic [pfp_pkg::DIV_W-1:0]       div_num, div_den;
  logic [pfp_pkg::QUO_W-1:0]       quo;
  logic [3:0]                      qcnt;
  logic [7:0]                      res [3];

  // Store address unit.
  logic [pfp_pkg::ROW_W-1:0] au_row;
  logic [pfp_pkg::COL_W-1:0] au_col;
  logic [pfp_pkg::LIN_W-1:0] au_lin, au_lin_d;
  logic [63:0]               au_prod;
  logic [31:0]               au_quot, au_rem;
  logic [pfp_pkg::LS_AW-1:0] ls_addr;

  // Memories.
  logic [pfp_pkg::PIX_W-1:0]  line_store [pfp_pkg::LS_DEPTH];
  logic [pfp_pkg::PIX_W-1:0]  ls_q;
  logic                       ls_we;
  logic [pfp_pkg::LOGW_W-1:0] lw_mem [pfp_pkg::WIN_N];
  logic [pfp_pkg::LOGW_W-1:0] lw_q, lw_wr_data;
  logic [pfp_pkg::WIN_AW-1:0] lw_rd_idx, lw_wr_idx;
  logic                       lw_we;

  // Combinational helpers.
  logic [pfp_pkg::WIDTH_W-1:0]    w_eff;
  logic [pfp_pkg::HEIGHT_W-1:0]   h_eff;
  logic [pfp_pkg::RAD_W-1:0]      rad_eff;
  logic [pfp_pkg::RAD_W-1:0]      qa;
  logic signed [pfp_pkg::OFF_W-1:0] p, q, fp, fq;
  logic signed [pfp_pkg::ROW_W+1:0] tr, pr;
  logic signed [pfp_pkg::COL_W+1:0] tc, pc;
  logic                           in_img;
  logic [pfp_pkg::RAD_W-1:0]      r_n, dp_n;
  logic                           psn_n, qsn_n;
  logic [pfp_pkg::CNT_W-1:0]      need;
  logic [pfp_pkg::LOGW_W-1:0]     neg_sat;
  logic [pfp_pkg::LOGW_W-3:0]     exp_idx;
  logic [26:0]                    term;
  logic [31:0]                    scale_sel;
  logic [pfp_pkg::PIX_W-1:0]      dist_a;
  logic [pfp_pkg::D2_W-1:0]       dist_sum;
  logic                           div_ge;
  logic [pfp_pkg::QUO_W-1:0]      quo_fin;
  logic                           ch_used;
  logic                           last;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  // Effective register values after clamping.
  always_comb begin
    if (image_width == '0) begin
      w_eff = pfp_pkg::WIDTH_W'(1);
    end else if (int'(image_width) > pfp_pkg::MAX_WIDTH) begin
      w_eff = pfp_pkg::WIDTH_W'(pfp_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff   = (image_height == '0) ? pfp_pkg::HEIGHT_W'(1) : image_height;
    rad_eff = (int'(radius) > pfp_pkg::MAX_RADIUS) ? pfp_pkg::RAD_W'(pfp_pkg::MAX_RADIUS)
                                                   : pfp_pkg::RAD_W'(radius);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= pfp_pkg::WIDTH_W'(1024);
      image_height  <= pfp_pkg::HEIGHT_W'(1024);
      radius        <= 3'd3;
      spatial_scale <= '0;
      range_scale   <= '0;
      color_mode    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (pfp_pkg::cfg_reg_t'(cfg_index))
        pfp_pkg::CFG_IMAGE_WIDTH:   image_width   <= cfg_data[pfp_pkg::WIDTH_W-1:0];
        pfp_pkg::CFG_IMAGE_HEIGHT:  image_height  <= cfg_data[pfp_pkg::HEIGHT_W-1:0];
        pfp_pkg::CFG_RADIUS:        radius        <= cfg_data[2:0];
        pfp_pkg::CFG_SPATIAL_SCALE: spatial_scale <= cfg_data;
        pfp_pkg::CFG_RANGE_SCALE:   range_scale   <= cfg_data;
        pfp_pkg::CFG_COLOR_MODE:    color_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Store address unit: row*width + col, then modulo the store depth by reciprocal.
  always_ff @(posedge clk) begin
    au_lin   <= pfp_pkg::LIN_W'(au_row) * pfp_pkg::LIN_W'(w_eff) + pfp_pkg::LIN_W'(au_col);
    au_lin_d <= au_lin;
    au_prod  <= 64'(au_lin) * pfp_pkg::LS_RECIP;
    ls_addr  <= (au_rem >= 32'(pfp_pkg::LS_DEPTH))
                ? pfp_pkg::LS_AW'(au_rem - 32'(pfp_pkg::LS_DEPTH))
                : pfp_pkg::LS_AW'(au_rem);
  end

  always_comb begin
    au_quot = au_prod[63:pfp_pkg::MOD_SHIFT];
    au_rem  = 32'(au_lin_d) - au_quot * 32'(pfp_pkg::LS_DEPTH);
  end

  // Line store, one port written and read at the unit's address.
  assign ls_we = (state == S_WRITE);

  always_ff @(posedge clk) begin
    if (ls_we) begin
      line_store[ls_addr] <= px;
    end
    ls_q <= line_store[ls_addr];
  end

  // Log weight store of the current window.
  always_ff @(posedge clk) begin
    if (lw_we) begin
      lw_mem[lw_wr_idx] <= lw_wr_data;
    end
    lw_q <= lw_mem[lw_rd_idx];
  end

  // Ring walk: current target, its parent and the next loop position.
  always_comb begin
    qa = r - dp;
    p  = psn ? $signed({1'b0, dp}) : -$signed({1'b0, dp});
    q  = qsn ? $signed({1'b0, qa}) : -$signed({1'b0, qa});
    if (dp == '0) begin
      fp = '0;
      fq = qsn ? q - 1 : q + 1;
    end else if (qa == '0) begin
      fp = psn ? p - 1 : p + 1;
      fq = '0;
    end else if (r[0]) begin
      fp = p;
      fq = qsn ? q - 1 : q + 1;
    end else begin
      fp = psn ? p - 1 : p + 1;
      fq = q;
    end
    tr = $signed({2'b00, emit_row}) + (pfp_pkg::ROW_W+2)'(p);
    tc = $signed({2'b00, emit_col}) + (pfp_pkg::COL_W+2)'(q);
    pr = $signed({2'b00, emit_row}) + (pfp_pkg::ROW_W+2)'(fp);
    pc = $signed({2'b00, emit_col}) + (pfp_pkg::COL_W+2)'(fq);
    in_img = (tr >= 0) && (tr < $signed({2'b00, h_eff})) &&
             (tc >= 0) && (tc < $signed({1'b0, w_eff}));

    r_n   = r;
    dp_n  = dp;
    psn_n = psn;
    qsn_n = 1'b0;
    if (!qsn && (qa != '0)) begin
      qsn_n = 1'b1;
    end else if (!psn && (dp != '0)) begin
      psn_n = 1'b1;
    end else begin
      psn_n = 1'b0;
      if (dp == r) begin
        dp_n = '0;
        r_n  = r + 1'b1;
      end else begin
        dp_n = dp + 1'b1;
      end
    end
  end

  assign lw_rd_idx = pfp_pkg::win_idx(fp, fq);

  // Window store writes: centre cleared at the start, each target after its sum.
  always_comb begin
    lw_we      = 1'b0;
    lw_wr_idx  = pfp_pkg::win_idx(p, q);
    lw_wr_data = neg_sat;
    if (state == S_CCAP) begin
      lw_we      = 1'b1;
      lw_wr_idx  = pfp_pkg::win_idx('0, '0);
      lw_wr_data = '0;
    end else if (state == S_WT) begin
      lw_we = 1'b1;
    end
  end

  // Shared arithmetic: colour distance, scaled term, saturation, weight and divide step.
  always_comb begin
    dist_a   = sel ? cpx : ppx;
    dist_sum = '0;
    for (int z = 0; z < 3; z++) begin
      logic signed [8:0]  df;
      logic        [15:0] sq;
      df = $signed({1'b0, pfp_pkg::chan_of(dist_a, 2'(z))}) -
           $signed({1'b0, pfp_pkg::chan_of(tpx, 2'(z))});
      sq = 16'(df * df);
      if ((z == 0) || (color_mode && (z < pfp_pkg::CHANNELS))) begin
        dist_sum = dist_sum + pfp_pkg::D2_W'(sq);
      end
    end
    scale_sel = sel ? range_scale : spatial_scale;
    term      = 27'(((51'(mhi) << 16) + 51'(mlo) + 51'(1 << 23)) >> 24);
    neg_sat   = (neg > pfp_pkg::NEG_W'(pfp_pkg::LOGW_MAX)) ? pfp_pkg::LOGW_MAX
                                                           : neg[pfp_pkg::LOGW_W-1:0];
    exp_idx   = neg_sat[pfp_pkg::LOGW_W-1:2];
    div_ge    = (div_num >= div_den);
    quo_fin   = {quo[pfp_pkg::QUO_W-2:0], div_ge};
    ch_used   = (ch == 2'd0) || (color_mode && (int'(ch) < pfp_pkg::CHANNELS));
    need      = base + pfp_pkg::CNT_W'(rad_eff) * pfp_pkg::CNT_W'(w_eff)
                + pfp_pkg::CNT_W'(rad_eff) + pfp_pkg::CNT_W'(1);
    last      = ((13'(emit_row) + 13'd1) >= 13'(h_eff)) &&
                ((11'(emit_col) + 11'd1) >= w_eff);
  end

  // Sequencer, counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_row   <= '0;
      in_col   <= '0;
      emit_row <= '0;
      emit_col <= '0;
      m_tvalid <= 1'b0;
      wcnt     <= '0;
      r        <= '0;
      dp       <= '0;
      psn      <= 1'b0;
      qsn      <= 1'b0;
      sel      <= 1'b0;
      ch       <= '0;
      qcnt     <= '0;
    end else begin
      // The output stage reloads the valid itself when it hands over a new result.
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            px <= s_tdata;
            if ((s_tuser == pfp_pkg::CMD_PIXEL) && (in_row < h_eff)) begin
              au_row <= in_row;
              au_col <= in_col;
              wcnt   <= '0;
              state  <= S_WADR;
            end else begin
              state <= S_CHK1;
            end
          end
        end
        S_WADR: begin
          if (wcnt == AU_WAIT) begin
            state <= S_WRITE;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        S_WRITE: begin
          if ((11'(in_col) + 11'd1) >= w_eff) begin
            in_col <= '0;
            in_row <= in_row + 1'b1;
          end else begin
            in_col <= in_col + 1'b1;
          end
          state <= S_CHK1;
        end
        S_CHK1: begin
          rcv   <= pfp_pkg::CNT_W'(in_row) * pfp_pkg::CNT_W'(w_eff) + pfp_pkg::CNT_W'(in_col);
          base  <= pfp_pkg::CNT_W'(emit_row) * pfp_pkg::CNT_W'(w_eff)
                   + pfp_pkg::CNT_W'(emit_col);
          state <= S_CHK2;
        end
        S_CHK2: begin
          if ((in_row < h_eff) && (rcv < need)) begin
            state <= S_IDLE;
          end else begin
            au_row <= emit_row;
            au_col <= emit_col;
            wcnt   <= '0;
            state  <= S_CADR;
          end
        end
        S_CADR: begin
          if (wcnt == AU_WAIT) begin
            state <= S_CCAP;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        S_CCAP: begin
          cpx <= ls_q;
          for (int z = 0; z < 3; z++) begin
            sums[z] <= pfp_pkg::SUM_W'(pfp_pkg::chan_of(ls_q, 2'(z))) << 16;
          end
          total <= pfp_pkg::TOTAL_W'(pfp_pkg::ONE_Q16);
          r     <= pfp_pkg::RAD_W'(1);
          dp    <= '0;
          psn   <= 1'b0;
          qsn   <= 1'b0;
          state <= S_TSEL;
        end
        S_TSEL: begin
          if (r > rad_eff) begin
            ch    <= '0;
            state <= S_DIVI;
          end else if (in_img) begin
            au_row <= tr[pfp_pkg::ROW_W-1:0];
            au_col <= tc[pfp_pkg::COL_W-1:0];
            wcnt   <= '0;
            state  <= S_TADR;
          end else begin
            r   <= r_n;
            dp  <= dp_n;
            psn <= psn_n;
            qsn <= qsn_n;
          end
        end
        S_TADR: begin
          if (wcnt == AU_WAIT) begin
            state <= S_TCAP;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        S_TCAP: begin
          tpx    <= ls_q;
          au_row <= pr[pfp_pkg::ROW_W-1:0];
          au_col <= pc[pfp_pkg::COL_W-1:0];
          wcnt   <= '0;
          state  <= S_PADR;
        end
        S_PADR: begin
          if (wcnt == AU_WAIT) begin
            state <= S_PCAP;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        S_PCAP: begin
          ppx   <= ls_q;
          neg   <= pfp_pkg::NEG_W'(lw_q);
          sel   <= 1'b0;
          state <= S_DIST;
        end
        S_DIST: begin
          d2    <= dist_sum;
          state <= S_MLO;
        end
        S_MLO: begin
          mlo   <= 34'(d2) * 34'(scale_sel[15:0]);
          state <= S_MHI;
        end
        S_MHI: begin
          mhi   <= 34'(d2) * 34'(scale_sel[31:16]);
          state <= S_MADD;
        end
        S_MADD: begin
          neg <= neg + pfp_pkg::NEG_W'(term);
          if (!sel) begin
            sel   <= 1'b1;
            state <= S_DIST;
          end else begin
            state <= S_WT;
          end
        end
        S_WT: begin
          wt    <= (int'(exp_idx) < pfp_pkg::EXP_TABLE_DEPTH)
                   ? pfp_pkg::EXP_ROM[exp_idx[pfp_pkg::EXP_AW-1:0]] : '0;
          ch    <= '0;
          state <= S_ACC;
        end
        S_ACC: begin
          sums[ch] <= sums[ch] + pfp_pkg::SUM_W'(wt * pfp_pkg::chan_of(tpx, ch));
          if (ch == 2'd0) begin
            total <= total + pfp_pkg::TOTAL_W'(wt);
          end
          if (ch == 2'd2) begin
            r     <= r_n;
            dp    <= dp_n;
            psn   <= psn_n;
            qsn   <= qsn_n;
            state <= S_TSEL;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        S_DIVI: begin
          div_num <= pfp_pkg::DIV_W'({sums[ch], 1'b0}) + pfp_pkg::DIV_W'(total);
          div_den <= pfp_pkg::DIV_W'(total) << pfp_pkg::QUO_W;
          quo     <= '0;
          qcnt    <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_ge) begin
            div_num <= div_num - div_den;
          end
          div_den <= div_den >> 1;
          quo     <= quo_fin;
          if (int'(qcnt) == pfp_pkg::QUO_W - 1) begin
            if (!ch_used) begin
              res[ch] <= '0;
            end else if (quo_fin > pfp_pkg::QUO_W'(255)) begin
              res[ch] <= 8'd255;
            end else begin
              res[ch] <= quo_fin[7:0];
            end
            if (ch == 2'd2) begin
              state <= S_OUT;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_DIVI;
            end
          end else begin
            qcnt <= qcnt + 1'b1;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, emit_col, emit_row, res[2], res[1], res[0]};
            m_tlast  <= last;
            if (last) begin
              in_row   <= '0;
              in_col   <= '0;
              emit_row <= '0;
              emit_col <= '0;
            end else if ((11'(emit_col) + 11'd1) >= w_eff) begin
              emit_col <= '0;
              emit_row <= emit_row + 1'b1;
            end else begin
              emit_col <= emit_col + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The reduced store address of a write always lands inside the line store.
  a_store_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (int'(ls_addr) < pfp_pkg::LS_DEPTH))
    else $error("line store write address out of range");

  // The divider remainder stays below twice the current shifted divisor.
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ({1'b0, div_num} < {div_den, 1'b0}))
    else $error("divider quotient overflow");

  // The ring walk never runs past one ring beyond the radius.
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TSEL) |-> ({1'b0, r} <= ({1'b0, rad_eff} + 1'b1)))
    else $error("ring counter ran past the window");
`endif

endmodule

/* verif/propagation_filter_pixel_test.sv */
// Self-checking testbench of the propagation filter: random frames, predicted outputs.
module propagation_filter_pixel_test;

  typedef struct packed {
    logic [7:0]  res_a;
    logic [7:0]  res_b;
    logic [7:0]  res_c;
    logic [11:0] row;
    logic [9:0]  col;
    logic        frame_end;
  } filt_px_t;

  typedef struct packed {
    logic        cmd;
    logic [23:0] px;
  } pix_req_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // chan_a, chan_b, chan_c
  logic        s_tuser = 1'b0; // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // res_a, res_b, res_c, out_row, out_col, zero pad
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  propagation_filter_pixel u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: configuration, line store, negated log weights, counters.
  int unsigned img_w, img_h, win_rad, sp_scale, rg_scale;
  bit          rgb_mode;
  logic [23:0] pix_mem [pfp_pkg::LS_DEPTH];
  int unsigned neglog [pfp_pkg::WIN_N];
  int unsigned exp_q16 [pfp_pkg::EXP_TABLE_DEPTH];
  int unsigned in_r, in_c, em_r, em_c;

  pix_req_t pix_reqs [$];
  filt_px_t expected_px [$];
  int       fail_count = 0;
  int       random_items = 0;
  bit       calm = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (calm || sel < 55) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  function automatic longint unsigned sq_dist(logic [23:0] a, logic [23:0] b, int nch);
    longint unsigned s;
    int d;
    s = 0;
    for (int z = 0; z < nch; z++) begin
      d = int'(a[8*z +: 8]) - int'(b[8*z +: 8]);
      s += longint'(d * d);
    end
    return s;
  endfunction

  function automatic longint unsigned scale_q8(longint unsigned d2, int unsigned sc);
    return (d2 * longint'(sc) + (64'd1 << 23)) >> 24;
  endfunction

  function automatic logic [23:0] pix_rd(int row, int col, int w);
    return pix_mem[(row * w + col) % pfp_pkg::LS_DEPTH];
  endfunction

  // One request through the predicted filter; returns 1 when an output is released.
  function automatic bit filter_step(input logic cmd, input logic [23:0] px,
                                     output filt_px_t o);
    int w, h, rad, nch, r, dp, ps, qs, p, q, fp, fq, tr, tc, er, ec;
    longint unsigned recvd, need, neg, v, total;
    longint unsigned sums [3];
    logic [23:0] cpx, tpx, ppx;
    int unsigned idx, wt;
    bit last;
    w = (img_w < 1) ? 1 : (img_w > pfp_pkg::MAX_WIDTH ? pfp_pkg::MAX_WIDTH : img_w);
    h = (img_h < 1) ? 1 : img_h;
    rad = (win_rad > pfp_pkg::MAX_RADIUS) ? pfp_pkg::MAX_RADIUS : win_rad;
    nch = rgb_mode ? pfp_pkg::CHANNELS : 1;
    o = '0;
    if (cmd == pfp_pkg::CMD_PIXEL && in_r < h) begin
      pix_mem[(in_r * w + in_c) % pfp_pkg::LS_DEPTH] = px;
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
      end
    end
    if (in_r < h) begin
      recvd = longint'(in_r) * w + in_c;
      need = longint'(em_r) * w + em_c + longint'(rad) * w + rad + 1;
      if (recvd < need) return 0;
    end
    er = em_r;
    ec = em_c;
    cpx = pix_rd(er, ec, w);
    total = pfp_pkg::ONE_Q16;
    for (int z = 0; z < 3; z++) sums[z] = longint'(cpx[8*z +: 8]) * pfp_pkg::ONE_Q16;
    neglog[pfp_pkg::MAX_RADIUS * pfp_pkg::WIN_SIDE + pfp_pkg::MAX_RADIUS] = 0;
    // Ring walk: each target inherits from its parent one step nearer the center.
    for (r = 1; r <= rad; r++) begin
      for (dp = 0; dp <= r; dp++) begin
        for (ps = -1; ps <= 1; ps += 2) begin
          p = ps * dp;
          for (qs = -1; qs <= 1; qs += 2) begin
            q = qs * (r - dp);
            tr = er + p;
            tc = ec + q;
            if (p == 0) begin
              fp = 0; fq = q - qs;
            end else if (q == 0) begin
              fp = p - ps; fq = 0;
            end else if (r % 2 == 1) begin
              fp = p; fq = q - qs;
            end else begin
              fp = p - ps; fq = q;
            end
            if (tr >= 0 && tr < h && tc >= 0 && tc < w) begin
              tpx = pix_rd(tr, tc, w);
              ppx = pix_rd(er + fp, ec + fq, w);
              neg = neglog[(fp + pfp_pkg::MAX_RADIUS) * pfp_pkg::WIN_SIDE + fq
                           + pfp_pkg::MAX_RADIUS];
              neg += scale_q8(sq_dist(ppx, tpx, nch), sp_scale);
              neg += scale_q8(sq_dist(cpx, tpx, nch), rg_scale);
              if (neg > 64'h3F_FFFF) neg = 64'h3F_FFFF;
              neglog[(p + pfp_pkg::MAX_RADIUS) * pfp_pkg::WIN_SIDE + q
                     + pfp_pkg::MAX_RADIUS] = int'(neg);
              idx = int'(neg >> 2);
              wt = (idx < pfp_pkg::EXP_TABLE_DEPTH) ? exp_q16[idx] : 0;
              total += wt;
              for (int z = 0; z < nch; z++) sums[z] += longint'(wt) * tpx[8*z +: 8];
            end
            if (q == 0) break;
          end
          if (p == 0) break;
        end
      end
    end
    for (int z = 0; z < 3; z++) begin
      v = 0;
      if (z < nch) begin
        v = (2 * sums[z] + total) / (2 * total);
        if (v > 255) v = 255;
      end
      if (z == 0) o.res_a = v[7:0];
      else if (z == 1) o.res_b = v[7:0];
      else o.res_c = v[7:0];
    end
    last = (er + 1 >= h) && (ec + 1 >= w);
    o.row = er[11:0];
    o.col = ec[9:0];
    o.frame_end = last;
    em_c++;
    if (em_c >= w) begin
      em_c = 0;
      em_r = (em_r + 1) & 12'hFFF;
    end
    if (last) begin
      in_r = 0; in_c = 0; em_r = 0; em_c = 0;
    end
    return 1;
  endfunction

  task automatic cfg_write(input pfp_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pfp_pkg::CFG_IMAGE_WIDTH:   img_w = val[10:0];
      pfp_pkg::CFG_IMAGE_HEIGHT:  img_h = val[11:0];
      pfp_pkg::CFG_RADIUS:        win_rad = val[2:0];
      pfp_pkg::CFG_SPATIAL_SCALE: sp_scale = val;
      pfp_pkg::CFG_RANGE_SCALE:   rg_scale = val;
      pfp_pkg::CFG_COLOR_MODE:    rgb_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pix_reqs.size() != 0 || expected_px.size() != 0 || s_tvalid) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [23:0] next_pixel(logic [23:0] prev);
    logic [23:0] n;
    int c;
    case ($urandom_range(0, 9))
      0: for (int z = 0; z < 3; z++) n[8*z +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1, 2, 3, 4, 5: for (int z = 0; z < 3; z++) begin
        c = int'(prev[8*z +: 8]) + $urandom_range(0, 16) - 8;
        n[8*z +: 8] = (c < 0) ? 8'd0 : (c > 255 ? 8'd255 : c[7:0]);
      end
      default: n = 24'($urandom());
    endcase
    return n;
  endfunction

  // One frame: configure while idle, then queue pixels and drains until the frame ends.
  task automatic run_frame(input int w, input int h, input int rad, input int unsigned ss,
                           input int unsigned rs, input bit cm, input bit directed);
    int ew, eh, sent, total_px;
    bit done;
    logic [23:0] px;
    pix_req_t req;
    filt_px_t o;
    wait_idle();
    cfg_write(pfp_pkg::CFG_IMAGE_WIDTH, w);
    cfg_write(pfp_pkg::CFG_IMAGE_HEIGHT, h);
    cfg_write(pfp_pkg::CFG_RADIUS, rad);
    cfg_write(pfp_pkg::CFG_SPATIAL_SCALE, ss);
    cfg_write(pfp_pkg::CFG_RANGE_SCALE, rs);
    cfg_write(pfp_pkg::CFG_COLOR_MODE, cm);
    calm = ($urandom_range(0, 4) == 0);
    ew = (w < 1) ? 1 : (w > pfp_pkg::MAX_WIDTH ? pfp_pkg::MAX_WIDTH : w);
    eh = (h < 1) ? 1 : h;
    total_px = ew * eh;
    sent = 0;
    done = 1'b0;
    px = 24'($urandom());
    while (!done) begin
      if (sent < total_px && $urandom_range(0, 9) != 0) begin
        // Directed frames open with the channel extremes.
        if (directed && sent < 4) begin
          case (sent)
            0: px = 24'h000000;
            1: px = 24'hFFFFFF;
            2: px = 24'h00FF00;
            default: px = 24'hFF00FF;
          endcase
        end else begin
          px = next_pixel(px);
        end
        req = '{cmd: pfp_pkg::CMD_PIXEL, px: px};
        sent++;
      end else if (sent >= total_px && $urandom_range(0, 9) == 0) begin
        // A pixel after the whole frame arrived is dropped.
        req = '{cmd: pfp_pkg::CMD_PIXEL, px: 24'($urandom())};
      end else begin
        req = '{cmd: pfp_pkg::CMD_DRAIN, px: 24'($urandom())};
      end
      pix_reqs.push_back(req);
      random_items++;
      if (filter_step(req.cmd, req.px, o)) begin
        expected_px.push_back(o);
        done = o.frame_end;
      end
    end
  endtask

  // Stimulus.
  initial begin
    longint unsigned v;
    int unsigned ss, rs;
    v = 64'd1 << 32;
    for (int i = 0; i < pfp_pkg::EXP_TABLE_DEPTH; i++) begin
      exp_q16[i] = int'((v + 64'h8000) >> 16);
      v = (v * 64'd4228380000 + 64'h8000_0000) >> 32;
    end
    img_w = 1024; img_h = 1024; win_rad = 3; sp_scale = 0; rg_scale = 0; rgb_mode = 1'b1;
    in_r = 0; in_c = 0; em_r = 0; em_c = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Tallest frame setting, replaced before any pixel is sent.
    cfg_write(pfp_pkg::CFG_IMAGE_HEIGHT, 4095);
    run_frame(3, 3, 1, 32'h0100_0000, 32'h0010_0000, 1'b1, 1'b1);
    run_frame(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    run_frame(4, 4, 7, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1);
    run_frame(5, 3, 2, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
    run_frame(1024, 1, 0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
    while (random_items < 1900) begin
      case ($urandom_range(0, 3))
        0: ss = 0;
        1: ss = 32'hFFFF_FFFF;
        default: ss = $urandom() >> $urandom_range(4, 14);
      endcase
      case ($urandom_range(0, 3))
        0: rs = 0;
        1: rs = 32'hFFFF_FFFF;
        default: rs = $urandom() >> $urandom_range(4, 14);
      endcase
      run_frame($urandom_range(0, 12), $urandom_range(0, 8),
                ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 3),
                ss, rs, $urandom_range(0, 1), 1'b0);
    end
    wait_idle();
    if (fail_count == 0) $display("propagation_filter_pixel verification clean");
    else $display("propagation_filter_pixel verification failed");
    $finish;
  end

  // Driver: presents queued requests with random gaps.
  int unsigned src_gap = 0;
  always @(posedge clk) begin
    if (!rst && (!s_tvalid || s_tready)) begin
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pix_reqs.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tuser <= pix_reqs[0].cmd;
        s_tdata <= pix_reqs[0].px;
        void'(pix_reqs.pop_front());
        src_gap <= gap_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, field checks and the stall watchdog.
  int unsigned sink_stall = 0;
  int          idle_cycles = 0;
  always @(posedge clk) begin
    filt_px_t want;
    if (!rst) begin
      if (sink_stall != 0) begin
        sink_stall <= sink_stall - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_stall <= gap_len();
      end
      if (m_tvalid && m_tready) begin
        if (expected_px.size() == 0) begin
          report("output with none expected");
        end else begin
          want = expected_px.pop_front();
          if (m_tdata[7:0] !== want.res_a)
            report($sformatf("res_a %0d, want %0d", m_tdata[7:0], want.res_a));
          if (m_tdata[15:8] !== want.res_b)
            report($sformatf("res_b %0d, want %0d", m_tdata[15:8], want.res_b));
          if (m_tdata[23:16] !== want.res_c)
            report($sformatf("res_c %0d, want %0d", m_tdata[23:16], want.res_c));
          if (m_tdata[35:24] !== want.row)
            report($sformatf("out_row %0d, want %0d", m_tdata[35:24], want.row));
          if (m_tdata[45:36] !== want.col)
            report($sformatf("out_col %0d, want %0d", m_tdata[45:36], want.col));
          if (m_tlast !== want.frame_end)
            report($sformatf("frame_end %0b, want %0b", m_tlast, want.frame_end));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
          (pix_reqs.size() == 0 && expected_px.size() == 0 && !s_tvalid)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("propagation_filter_pixel verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
